[rtl/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared codes and control types of the four-level stack calculator.
// ----------------------------------------------------------------------------
package fsc_pkg;

	// instruction codes
	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_LOADI  = 4'd1;
	localparam logic [3:0] OP_LOADM  = 4'd2;
	localparam logic [3:0] OP_STORM  = 4'd3;
	localparam logic [3:0] OP_ADD    = 4'd4;
	localparam logic [3:0] OP_SUB    = 4'd5;
	localparam logic [3:0] OP_MUL    = 4'd6;
	localparam logic [3:0] OP_DIV    = 4'd7;
	localparam logic [3:0] OP_REM    = 4'd8;
	localparam logic [3:0] OP_INC    = 4'd9;
	localparam logic [3:0] OP_DEC    = 4'd10;
	localparam logic [3:0] OP_NEG    = 4'd11;
	localparam logic [3:0] OP_CLRSTK = 4'd12;
	localparam logic [3:0] OP_CLRMEM = 4'd13;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_ADDR = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic mem_rd;
		logic arith_start;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_mem;
		logic need_arith;
		logic arith_done;
	} sts_t;

endpackage

[rtl/fsc_in_if.sv]
// ----------------------------------------------------------------------------
// fsc_in_if
// Instruction channel: valid/ready handshake with opcode and operands.
// ----------------------------------------------------------------------------
interface fsc_in_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  opcode;
	logic signed [31:0] immediate;
	logic        [7:0]  address;

	modport source (output valid, opcode, immediate, address, input ready);
	modport sink   (input valid, opcode, immediate, address, output ready);
endinterface

[rtl/fsc_out_if.sv]
// ----------------------------------------------------------------------------
// fsc_out_if
// Result channel: valid/ready handshake with the stack view and status.
// ----------------------------------------------------------------------------
interface fsc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top;
	logic signed [31:0] second;
	logic signed [31:0] third;
	logic signed [31:0] fourth;
	logic        [1:0]  status;

	modport source (output valid, top, second, third, fourth, status, input ready);
	modport sink   (input valid, top, second, third, fourth, status, output ready);
endinterface

[rtl/four_level_stack_calculator.sv]
// ----------------------------------------------------------------------------
// four_level_stack_calculator
// Stack calculator: one instruction word in, one stack view word out.
// ----------------------------------------------------------------------------
// Each instruction word yields exactly one result word showing the top four
// stack entries and a status. Words are handled one at a time. Each word
// goes from acceptance through decode to commit, and the result word is
// registered at commit. Load from memory at a valid address adds a memory
// step for the registered memory read. Multiply, and divide and remainder
// by a nonzero top entry, add the iteration steps of the bit-serial
// multiply/divide unit. The next word can be taken in the cycle after the
// result is committed.
// A new word is taken while the previous result still waits at the output;
// its own result then waits in the commit step until the output slot frees.
// No clearing pass after reset: memory entries carry valid bits.
module four_level_stack_calculator #(
	parameter int STACK_DEPTH = 4,
	parameter int MEM_DEPTH   = 16,
	parameter int WORD_WIDTH  = 32
) (
	input logic       clk,
	input logic       arst_n,
	fsc_in_if.sink    instr,
	fsc_out_if.source result
);
	fsc_pkg::cmd_t cmd;
	fsc_pkg::sts_t sts;

	fsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (instr.valid),
		.in_ready  (instr.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fsc_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.MEM_DEPTH   (MEM_DEPTH),
		.WORD_WIDTH  (WORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (instr.opcode),
		.immediate (instr.immediate),
		.address   (instr.address),
		.top       (result.top),
		.second    (result.second),
		.third     (result.third),
		.fourth    (result.fourth),
		.status    (result.status)
	);
endmodule

[rtl/fsc_arith.sv]
// ----------------------------------------------------------------------------
// fsc_arith
// Iterative unit: shift-add multiply and restoring signed divide/remainder,
// one bit per cycle.
// ----------------------------------------------------------------------------
module fsc_arith #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  is_mul,
	input  logic                  is_rem,
	input  logic [WORD_WIDTH-1:0] a,
	input  logic [WORD_WIDTH-1:0] b,
	output logic                  done,
	output logic [WORD_WIDTH-1:0] result
);
	localparam int W  = WORD_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          mul_q;
	logic          rem_q;
	logic          neg_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  shf_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    rem_sh;
	logic [W:0]    diff;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W-1:0]  raw;

	assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
	assign rem_sh = {acc_q, shf_q[W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			mul_q <= is_mul;
			rem_q <= is_rem;
			acc_q <= '0;
			if (is_mul) begin
				shf_q <= b;
				dvs_q <= a;
				neg_q <= 1'b0;
			end else begin
				shf_q <= mag_b;
				dvs_q <= mag_a;
				neg_q <= is_rem ? b[W-1] : (a[W-1] ^ b[W-1]);
			end
		end else if (busy_q) begin
			if (mul_q) begin
				acc_q <= acc_q + (shf_q[0] ? dvs_q : '0);
				shf_q <= shf_q >> 1;
				dvs_q <= dvs_q << 1;
			end else if (!diff[W]) begin
				acc_q <= diff[W-1:0];
				shf_q <= {shf_q[W-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh[W-1:0];
				shf_q <= {shf_q[W-2:0], 1'b0};
			end
		end
	end

	// final sign fix
	assign raw    = (mul_q || rem_q) ? acc_q : shf_q;
	assign result = neg_q ? (~raw + 1'b1) : raw;
	assign done   = done_q;
endmodule

[rtl/fsc_dp.sv]
// ----------------------------------------------------------------------------
// fsc_dp
// Datapath: instruction latch, register stack, data memory and arith unit.
// ----------------------------------------------------------------------------
module fsc_dp #(
	parameter int STACK_DEPTH = 4,
	parameter int MEM_DEPTH   = 16,
	parameter int WORD_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsc_pkg::cmd_t        cmd,
	output fsc_pkg::sts_t        sts,
	input  logic        [3:0]    opcode,
	input  logic signed [31:0]   immediate,
	input  logic        [7:0]    address,
	output logic signed [31:0]   top,
	output logic signed [31:0]   second,
	output logic signed [31:0]   third,
	output logic signed [31:0]   fourth,
	output logic        [1:0]    status
);
	localparam int W  = WORD_WIDTH;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic        [3:0]  op_q;
	logic signed [31:0] imm_q;
	logic        [7:0]  addr_q;

	logic [W-1:0] stk_q [STACK_DEPTH];
	logic [W-1:0] stk_d [STACK_DEPTH];
	logic [1:0]   status_q;
	logic [1:0]   status_d;

	logic [W-1:0]         mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] vld_q;
	logic [W-1:0]         rd_q;
	logic                 rd_vld_q;

	logic [AW-1:0] idx;
	logic          addr_ok;
	logic          top_zero;
	logic          is_divrem;
	logic          wr_en;
	logic [W-1:0]  imm_w;
	logic [W-1:0]  rd_w;
	logic          arith_done;
	logic [W-1:0]  arith_res;

	assign idx       = addr_q[AW-1:0];
	assign addr_ok   = {1'b0, addr_q} < 9'(MEM_DEPTH);
	assign top_zero  = (stk_q[0] == '0);
	assign is_divrem = (op_q == fsc_pkg::OP_DIV) || (op_q == fsc_pkg::OP_REM);
	assign imm_w     = W'(imm_q);
	assign rd_w      = rd_vld_q ? rd_q : '0;

	assign sts.need_mem   = (op_q == fsc_pkg::OP_LOADM) && addr_ok;
	assign sts.need_arith = (op_q == fsc_pkg::OP_MUL) || (is_divrem && !top_zero);
	assign sts.arith_done = arith_done;

	// instruction latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= opcode;
			imm_q  <= immediate;
			addr_q <= address;
		end
	end

	fsc_arith #(
		.WORD_WIDTH(W)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.arith_start),
		.is_mul (op_q == fsc_pkg::OP_MUL),
		.is_rem (op_q == fsc_pkg::OP_REM),
		.a      (stk_q[0]),
		.b      (stk_q[1]),
		.done   (arith_done),
		.result (arith_res)
	);

	// next stack and status
	always_comb begin
		stk_d    = stk_q;
		status_d = fsc_pkg::ST_OK;
		wr_en    = 1'b0;
		unique case (op_q)
			fsc_pkg::OP_LOADI, fsc_pkg::OP_LOADM: begin
				if (op_q == fsc_pkg::OP_LOADM && !addr_ok) begin
					status_d = fsc_pkg::ST_ADDR;
				end else begin
					for (int k = 1; k < STACK_DEPTH; k++) stk_d[k] = stk_q[k-1];
					stk_d[0] = (op_q == fsc_pkg::OP_LOADI) ? imm_w : rd_w;
				end
			end
			fsc_pkg::OP_STORM: begin
				if (!addr_ok) begin
					status_d = fsc_pkg::ST_ADDR;
				end else begin
					wr_en = 1'b1;
					for (int k = 0; k < STACK_DEPTH - 1; k++) stk_d[k] = stk_q[k+1];
					stk_d[STACK_DEPTH-1] = '0;
				end
			end
			fsc_pkg::OP_ADD, fsc_pkg::OP_SUB, fsc_pkg::OP_MUL,
			fsc_pkg::OP_DIV, fsc_pkg::OP_REM: begin
				if (is_divrem && top_zero) begin
					status_d = fsc_pkg::ST_DIV0;
				end else begin
					if (op_q == fsc_pkg::OP_ADD)      stk_d[0] = stk_q[0] + stk_q[1];
					else if (op_q == fsc_pkg::OP_SUB) stk_d[0] = stk_q[1] - stk_q[0];
					else                              stk_d[0] = arith_res;
					for (int k = 1; k < STACK_DEPTH - 1; k++) stk_d[k] = stk_q[k+1];
					stk_d[STACK_DEPTH-1] = '0;
				end
			end
			fsc_pkg::OP_INC:    stk_d[0] = stk_q[0] + 1'b1;
			fsc_pkg::OP_DEC:    stk_d[0] = stk_q[0] - 1'b1;
			fsc_pkg::OP_NEG:    stk_d[0] = ~stk_q[0] + 1'b1;
			fsc_pkg::OP_CLRSTK: begin
				for (int k = 0; k < STACK_DEPTH; k++) stk_d[k] = '0;
			end
			default: ;
		endcase
	end

	// stack and status registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < STACK_DEPTH; k++) stk_q[k] <= '0;
			status_q <= fsc_pkg::ST_OK;
		end else if (cmd.commit) begin
			stk_q    <= stk_d;
			status_q <= status_d;
		end
	end

	// memory entry valid bits, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.commit) begin
			if (op_q == fsc_pkg::OP_CLRMEM) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[idx] <= 1'b1;
			end
		end
	end

	// data memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem_q[idx] <= stk_q[0];
		end
		if (cmd.mem_rd) begin
			rd_q     <= mem_q[idx];
			rd_vld_q <= vld_q[idx];
		end
	end

	// stack view, entries beyond the stack read as zero
	function automatic logic signed [31:0] view(input int k);
		logic [63:0] v;
		v = '0;
		if (k < STACK_DEPTH) v = 64'(stk_q[k]);
		return v[31:0];
	endfunction

	assign top    = view(0);
	assign second = view(1);
	assign third  = view(2);
	assign fourth = view(3);
	assign status = status_q;
endmodule

[rtl/fsc_ctrl.sv]
// ----------------------------------------------------------------------------
// fsc_ctrl
// Controller: sequences decode, memory read, iteration and commit, and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module fsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  fsc_pkg::sts_t sts,
	output fsc_pkg::cmd_t cmd
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_MEM    = 3'd2;
	localparam logic [2:0] S_ARITH  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd.latch       = 1'b0;
		cmd.mem_rd      = 1'b0;
		cmd.arith_start = 1'b0;
		cmd.commit      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.need_mem) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_MEM;
				end else if (sts.need_arith) begin
					cmd.arith_start = 1'b1;
					state_d         = S_ARITH;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_MEM: state_d = S_COMMIT;
			S_ARITH: begin
				if (sts.arith_done) state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule

[rtl/fsc_checker.sv]
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the stack calculator, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] top,
	input logic [1:0]  status
);
	// one word in flight: no new word right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while previous still in work");

	// status is one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == fsc_pkg::ST_OK) || (status == fsc_pkg::ST_DIV0)
			|| (status == fsc_pkg::ST_ADDR))
		else $error("undefined status code");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top) && $stable(status))
		else $error("stalled result word changed");

	// a word taken while no result waits does not raise the result valid at once
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result word appeared too early");
endmodule

bind four_level_stack_calculator fsc_checker u_fsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr.valid),
	.in_ready  (instr.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.top       (result.top),
	.status    (result.status)
);
